// File: design/mrgf_pkg.sv
// Shared types, constants and the CRC-16 byte update for the gripper framer.
package mrgf_pkg;

  typedef enum logic [1:0] {
    CMD_ACTION   = 2'd0,
    CMD_POSITION = 2'd1,
    CMD_STATUS   = 2'd2,
    CMD_RX       = 2'd3
  } cmd_t;

  localparam logic [7:0]  FN_WRITE        = 8'h10;
  localparam logic [7:0]  FN_READ         = 8'h04;
  localparam logic [15:0] FIRST_OUT_REG   = 16'h03E8;
  localparam logic [15:0] FIRST_IN_REG    = 16'h07D0;
  localparam logic [7:0]  WRITE_REG_COUNT = 8'h03;
  localparam logic [7:0]  READ_REG_COUNT  = 8'h02;
  localparam logic [7:0]  WRITE_BYTE_COUNT = 8'h06;
  localparam logic [7:0]  GOTO_ACTIVATE   = 8'h09;

  localparam logic [3:0]  WRITE_REPLY_LEN = 4'd8;
  localparam logic [3:0]  READ_REPLY_LEN  = 4'd9;
  localparam logic [3:0]  WRITE_FRAME_LEN = 4'd15;
  localparam logic [3:0]  READ_FRAME_LEN  = 4'd8;
  localparam logic [3:0]  DATA_FIRST      = 4'd3;
  localparam logic [3:0]  DATA_LAST       = 4'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0]  SLAVE_ID_RESET      = 8'd9;
  localparam int          QUEUE_DEPTH_DEFAULT = 2;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic             is_verdict;
    cmd_t             cmd;
    logic [7:0]       action_bits;
    logic [7:0]       position;
    logic [7:0]       speed;
    logic [7:0]       force_req;
    logic             crc_ok;
    logic             id_ok;
    logic [3:0][7:0]  data;
  } job_t;

  // Reflected CRC-16 over one byte, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: design/mrgf_front.sv
// Front end: accepts items, tracks the pending reply and queues frame and verdict jobs.
module mrgf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        slave_id,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [7:0]        action_bits,
  input  logic [7:0]        position,
  input  logic [7:0]        speed,
  input  logic [7:0]        force_req,
  input  logic [7:0]        rx_byte,
  input  logic              q_full,
  output logic              q_push,
  output mrgf_pkg::job_t    q_data
);
  import mrgf_pkg::*;

  logic             reply_pending;
  logic [3:0]       expected_length;
  logic [3:0]       received_count;
  logic [15:0]      reply_crc;
  logic [7:0]       first_byte;
  logic [7:0]       prev_byte;
  logic [3:0][7:0]  data_bytes;

  logic             accept;
  logic             is_request;
  logic             rx_take;
  logic             rx_final;
  logic [3:0]       count_inc;
  logic [1:0]       data_slot;
  cmd_t             cmd;

  assign cmd        = cmd_t'(command);
  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign is_request = (cmd != CMD_RX);
  assign rx_take    = accept && !is_request && reply_pending;
  assign count_inc  = received_count + 4'd1;
  assign rx_final   = rx_take && (count_inc == expected_length);
  assign data_slot  = 2'(received_count - DATA_FIRST);

  always_comb begin
    q_push = (accept && is_request) || rx_final;
    q_data = '0;
    q_data.is_verdict  = !is_request;
    q_data.cmd         = cmd;
    q_data.action_bits = action_bits;
    q_data.position    = position;
    q_data.speed       = speed;
    q_data.force_req   = force_req;
    // The final byte is the CRC high byte; the one before it the low byte.
    q_data.crc_ok      = (reply_crc[7:0] == prev_byte) && (reply_crc[15:8] == rx_byte);
    q_data.id_ok       = (first_byte == slave_id);
    q_data.data        = data_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_pending   <= 1'b0;
      expected_length <= 4'd0;
      received_count  <= 4'd0;
      reply_crc       <= CRC_INIT;
    end else if (accept && is_request) begin
      // Arm a fresh reply, abandoning any one still in progress.
      reply_pending   <= 1'b1;
      expected_length <= (cmd == CMD_STATUS) ? READ_REPLY_LEN : WRITE_REPLY_LEN;
      received_count  <= 4'd0;
      reply_crc       <= CRC_INIT;
    end else if (rx_take) begin
      received_count <= count_inc;
      if ((received_count + 4'd2) < expected_length) begin
        reply_crc <= crc_byte(reply_crc, rx_byte);
      end
      if (rx_final) begin
        reply_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      prev_byte <= rx_byte;
      if (received_count == 4'd0) begin
        first_byte <= rx_byte;
      end
      if (received_count >= DATA_FIRST && received_count <= DATA_LAST) begin
        data_bytes[data_slot] <= rx_byte;
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    reply_pending |-> (received_count < expected_length))
    else $error("received count reached expected length while reply pending");

endmodule

// File: design/mrgf_queue.sv
// Short job queue between the front and back ends.
module mrgf_queue #(
  parameter int DEPTH = mrgf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrgf_pkg::job_t  push_data,
  output logic            full,
  input  logic            pop,
  output mrgf_pkg::job_t  pop_data,
  output logic            empty
);
  import mrgf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full job queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty job queue");

endmodule

// File: design/mrgf_back.sv
// Back end: serializes frame bytes with running CRC and emits verdicts.
module mrgf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      slave_id,
  input  mrgf_pkg::job_t  head,
  input  logic            head_empty,
  output logic            head_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            kind,
  output logic [7:0]      tx_byte,
  output logic            last,
  output logic            crc_ok,
  output logic            id_ok,
  output logic [7:0]      data_byte0,
  output logic [7:0]      data_byte1,
  output logic [7:0]      data_byte2,
  output logic [7:0]      data_byte3
);
  import mrgf_pkg::*;

  logic [3:0]   idx;
  logic [15:0]  crc;
  logic         load;
  logic [3:0]   frame_len;
  logic [7:0]   body_byte;
  logic [7:0]   cur_byte;
  logic         in_body;
  logic         last_byte;

  function automatic logic [7:0] frame_byte(input job_t j, input logic [3:0] i,
                                            input logic [7:0] id);
    logic [7:0] b;
    logic       act;
    b   = 8'h00;
    act = (j.cmd == CMD_ACTION);
    if (j.cmd == CMD_STATUS) begin
      case (i)
        4'd0:    b = id;
        4'd1:    b = FN_READ;
        4'd2:    b = FIRST_IN_REG[15:8];
        4'd3:    b = FIRST_IN_REG[7:0];
        4'd5:    b = READ_REG_COUNT;
        default: b = 8'h00;
      endcase
    end else begin
      case (i)
        4'd0:    b = id;
        4'd1:    b = FN_WRITE;
        4'd2:    b = FIRST_OUT_REG[15:8];
        4'd3:    b = FIRST_OUT_REG[7:0];
        4'd5:    b = WRITE_REG_COUNT;
        4'd6:    b = WRITE_BYTE_COUNT;
        4'd7:    b = act ? j.action_bits : GOTO_ACTIVATE;
        4'd10:   b = act ? 8'h00 : j.position;
        4'd11:   b = act ? 8'h00 : j.speed;
        4'd12:   b = act ? 8'h00 : j.force_req;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  assign frame_len = (head.cmd == CMD_STATUS) ? READ_FRAME_LEN : WRITE_FRAME_LEN;
  assign in_body   = idx < (frame_len - 4'd2);
  assign last_byte = (idx == (frame_len - 4'd1));
  assign body_byte = frame_byte(head, idx, slave_id);
  assign cur_byte  = in_body ? body_byte :
                     (idx == (frame_len - 4'd2)) ? crc[7:0] : crc[15:8];

  assign load     = !head_empty && (!out_valid || !out_stall);
  assign head_pop = load && (head.is_verdict || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
      crc       <= CRC_INIT;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && !head.is_verdict) begin
        if (last_byte) begin
          idx <= 4'd0;
          crc <= CRC_INIT;
        end else begin
          idx <= idx + 4'd1;
          if (in_body) begin
            crc <= crc_byte(crc, body_byte);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= head.is_verdict;
      tx_byte    <= head.is_verdict ? 8'h00 : cur_byte;
      last       <= head.is_verdict || last_byte;
      crc_ok     <= head.is_verdict && head.crc_ok;
      id_ok      <= head.is_verdict && head.id_ok;
      data_byte0 <= head.is_verdict ? head.data[0] : 8'h00;
      data_byte1 <= head.is_verdict ? head.data[1] : 8'h00;
      data_byte2 <= head.is_verdict ? head.data[2] : 8'h00;
      data_byte3 <= head.is_verdict ? head.data[3] : 8'h00;
    end
  end

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> last)
    else $error("verdict item without last");

endmodule

// File: design/modbus_rtu_gripper_framer_top.sv
// Top level of the Modbus RTU gripper framer: config register, front, job queue, back.
//
// Modbus RTU master framer for a gripper. Each request item (action, position or
// status read) produces one result item per frame byte, 15 bytes for a write and
// 8 for the status read, ending with a CRC-16 (reflected 0xA001, seed 0xFFFF)
// sent low byte first; last marks the final byte. A request also arms reception
// of the reply: 8 bytes for a write, 9 for the read. Received-byte items are
// checked as they arrive, one per cycle while the job queue has room, and give
// no result until the last expected byte, which yields one verdict item (kind 1)
// with crc_ok, id_ok and reply bytes 3 to 6. Received bytes with no reply pending
// are dropped, and a new request abandons a reply in progress. The back end emits
// one result item per cycle while out_stall is low, one per frame byte or verdict;
// this byte serializer sets the sustained rate. The front end takes
// an item every cycle while the job queue (QUEUE_DEPTH jobs, at least 2) has room,
// and stalls the input only when the queue is full. The output is registered, so
// an item can be accepted while a finished result still waits. slave_id resets
// to 9 and is written through the cfg channel, which is always ready.
module modbus_rtu_gripper_framer_top #(
  parameter int QUEUE_DEPTH = mrgf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  action_bits,
  input  logic [7:0]  position,
  input  logic [7:0]  speed,
  input  logic [7:0]  force_req,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic        crc_ok,
  output logic        id_ok,
  output logic [7:0]  data_byte0,
  output logic [7:0]  data_byte1,
  output logic [7:0]  data_byte2,
  output logic [7:0]  data_byte3
);
  import mrgf_pkg::*;

  logic [7:0]  slave_id;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  job_t        q_in;
  job_t        q_head;

  // Hold the slave address; the write channel never waits.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_id <= SLAVE_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slave_id <= cfg_data;
    end
  end

  // Classify items and track the pending reply.
  mrgf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .slave_id    (slave_id),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .action_bits (action_bits),
    .position    (position),
    .speed       (speed),
    .force_req   (force_req),
    .rx_byte     (rx_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  // Decouple the two sides so each stalls on its own.
  mrgf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  // Serialize frames and emit verdicts, one result item per cycle while the output is not stalled.
  mrgf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .slave_id   (slave_id),
    .head       (q_head),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .last       (last),
    .crc_ok     (crc_ok),
    .id_ok      (id_ok),
    .data_byte0 (data_byte0),
    .data_byte1 (data_byte1),
    .data_byte2 (data_byte2),
    .data_byte3 (data_byte3)
  );

endmodule

// File: tb/modbus_frame_checker.sv
// Checker for the gripper framer: predicts frame bytes and reply verdicts, compares results.
`timescale 1ns / 1ps
module modbus_frame_checker
  import mrgf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] action_bits,
  input  logic [7:0] position,
  input  logic [7:0] speed,
  input  logic [7:0] force_req,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       kind,
  input  logic [7:0] tx_byte,
  input  logic       last,
  input  logic       crc_ok,
  input  logic       id_ok,
  input  logic [7:0] data_byte0,
  input  logic [7:0] data_byte1,
  input  logic [7:0] data_byte2,
  input  logic [7:0] data_byte3,
  output int         mismatches,
  output int         owed
);

  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [7:0]      tx_byte;
    logic            last;
    logic            crc_ok;
    logic            id_ok;
    logic [3:0][7:0] data;
  } framer_out_t;

  framer_out_t owed_q[$];
  int          bad_count = 0;

  // Model copy of the block state.
  logic [7:0]  id_reg;
  logic        awaiting_reply;
  logic [3:0]  reply_len;
  logic [3:0]  rx_count;
  logic [15:0] rx_crc;
  logic [7:0]  rx_bytes [0:8];

  assign mismatches = bad_count;

  function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
    return r;
  endfunction

  // Build the whole request frame, append its CRC and queue one byte per result.
  task automatic frame_request(input cmd_t c, input logic [7:0] act, input logic [7:0] pos,
                               input logic [7:0] spd, input logic [7:0] frc);
    logic [7:0]  fb[$];
    logic [15:0] acc;
    framer_out_t o;
    if (c == CMD_STATUS) begin
      fb = {id_reg, FN_READ, FIRST_IN_REG[15:8], FIRST_IN_REG[7:0], 8'h00, READ_REG_COUNT};
      reply_len = READ_REPLY_LEN;
    end else begin
      fb = {id_reg, FN_WRITE, FIRST_OUT_REG[15:8], FIRST_OUT_REG[7:0], 8'h00,
            WRITE_REG_COUNT, WRITE_BYTE_COUNT};
      if (c == CMD_ACTION) begin
        fb = {fb, act, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      end else begin
        fb = {fb, GOTO_ACTIVATE, 8'h00, 8'h00, pos, spd, frc};
      end
      reply_len = WRITE_REPLY_LEN;
    end
    acc = CRC_INIT;
    foreach (fb[i]) acc = crc16_modbus(acc, fb[i]);
    fb.push_back(acc[7:0]);
    fb.push_back(acc[15:8]);
    foreach (fb[i]) begin
      o = '0;
      o.kind = KIND_TX;
      o.tx_byte = fb[i];
      o.last = (i == fb.size() - 1);
      owed_q.push_back(o);
    end
    awaiting_reply = 1'b1;
    rx_count = '0;
    rx_crc = CRC_INIT;
  endtask

  // Collect one reply byte; the final one yields the verdict.
  task automatic take_rx_byte(input logic [7:0] b);
    framer_out_t o;
    if (!awaiting_reply) return;
    if (rx_count < 9) rx_bytes[rx_count] = b;
    if (rx_count + 2 < reply_len) rx_crc = crc16_modbus(rx_crc, b);
    rx_count = rx_count + 4'd1;
    if (rx_count < reply_len) return;
    o = '0;
    o.kind = KIND_VERDICT;
    o.last = 1'b1;
    o.crc_ok = (rx_crc[7:0] == rx_bytes[reply_len - 2]) &&
               (rx_crc[15:8] == rx_bytes[reply_len - 1]);
    o.id_ok = (rx_bytes[0] == id_reg);
    for (int i = 0; i < 4; i++) o.data[i] = rx_bytes[DATA_FIRST + i];
    awaiting_reply = 1'b0;
    owed_q.push_back(o);
  endtask

  task automatic check_result();
    framer_out_t got, want;
    got = '0;
    got.kind = kind;
    got.tx_byte = tx_byte;
    got.last = last;
    got.crc_ok = crc_ok;
    got.id_ok = id_ok;
    got.data = {data_byte3, data_byte2, data_byte1, data_byte0};
    if (owed_q.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("%0t: unexpected result kind %0d tx_byte %02h last %0d", $time,
                 got.kind, got.tx_byte, got.last);
      return;
    end
    want = owed_q.pop_front();
    if (got !== want) begin
      bad_count++;
      if (bad_count <= 10) begin
        $display("%0t: mismatch, expected kind %0d tx %02h last %0d crc %0d id %0d data %08h",
                 $time, want.kind, want.tx_byte, want.last, want.crc_ok, want.id_ok,
                 want.data);
        $display("%0t: mismatch, actual   kind %0d tx %02h last %0d crc %0d id %0d data %08h",
                 $time, got.kind, got.tx_byte, got.last, got.crc_ok, got.id_ok, got.data);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      id_reg = SLAVE_ID_RESET;
      awaiting_reply = 1'b0;
      reply_len = '0;
      rx_count = '0;
      rx_crc = CRC_INIT;
      for (int i = 0; i < 9; i++) rx_bytes[i] = '0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) begin
        if (cmd_t'(command) == CMD_RX) begin
          take_rx_byte(rx_byte);
        end else begin
          frame_request(cmd_t'(command), action_bits, position, speed, force_req);
        end
      end
      if (cfg_valid && cfg_ready) id_reg = cfg_data;
    end
    owed <= owed_q.size();
  end

endmodule

// File: tb/modbus_rtu_gripper_framer_top_tb.sv
// Testbench top for the gripper framer: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps
module modbus_rtu_gripper_framer_top_tb;
  import mrgf_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_ACTION;
  logic [7:0] action_bits = '0;
  logic [7:0] position = '0;
  logic [7:0] speed = '0;
  logic [7:0] force_req = '0;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       kind;
  logic [7:0] tx_byte;
  logic       last;
  logic       crc_ok;
  logic       id_ok;
  logic [7:0] data_byte0;
  logic [7:0] data_byte1;
  logic [7:0] data_byte2;
  logic [7:0] data_byte3;
  int         mismatches;
  int         owed;

  // Idle rates in percent for the sender gaps and the receiver stalls.
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  // Stimulus-side view: current slave id and the reply length the last request armed.
  logic [7:0] cur_id = SLAVE_ID_RESET;
  logic [3:0] reply_len_now = '0;
  // Requests and reply bytes sent so far; stray bytes are left out.
  int         counted = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modbus_rtu_gripper_framer_top dut (.*);

  modbus_frame_checker frame_check (.*);

  // Stall the result channel at random, one decision per cycle.
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Present one item, with a random gap first, and hold it until accepted.
  task automatic send_item(input cmd_t c, input logic [7:0] act, input logic [7:0] pos,
                           input logic [7:0] spd, input logic [7:0] frc,
                           input logic [7:0] rxb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    action_bits <= act;
    position <= pos;
    speed <= spd;
    force_req <= frc;
    rx_byte <= rxb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send a request and note the reply length it arms.
  task automatic request(input cmd_t c, input logic [7:0] act, input logic [7:0] pos,
                         input logic [7:0] spd, input logic [7:0] frc);
    send_item(c, act, pos, spd, frc, 8'($urandom));
    reply_len_now = (c == CMD_STATUS) ? READ_REPLY_LEN : WRITE_REPLY_LEN;
    counted++;
  endtask

  // Send one received byte; the request fields carry noise.
  task automatic rx(input logic [7:0] b);
    send_item(CMD_RX, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), b);
  endtask

  // Build a reply for the armed length with random content and send its first upto bytes.
  // Break the id or one byte of the frame on request.
  task automatic send_reply(input int upto, input logic id_good, input logic crc_good);
    logic [7:0]  rb [0:8];
    logic [15:0] acc;
    int          n;
    n = reply_len_now;
    for (int i = 0; i < 9; i++) rb[i] = 8'($urandom);
    rb[0] = id_good ? cur_id : cur_id ^ 8'($urandom_range(1, 255));
    rb[1] = (n == READ_REPLY_LEN) ? FN_READ : FN_WRITE;
    acc = CRC_INIT;
    for (int i = 0; i < n - 2; i++) acc = crc_byte(acc, rb[i]);
    rb[n - 2] = acc[7:0];
    rb[n - 1] = acc[15:8];
    if (!crc_good) rb[$urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < upto; i++) begin
      rx(rb[i]);
      counted++;
    end
  endtask

  // Drop valid and wait until every owed result is out, then let in-flight bytes drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (32) @(posedge clk);
  endtask

  // Write the slave id while idle, set the idle rates and run random traffic.
  task automatic run_phase(input logic [7:0] id, input int send_pct, input int recv_pct,
                           input int target);
    int   pick;
    cmd_t c;
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= id;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_id = id;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      c = cmd_t'($urandom_range(0, 2));
      request(c, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      if (pick < 65) begin
        // Full reply, mostly clean, sometimes a wrong id or a damaged byte.
        send_reply(reply_len_now, $urandom_range(0, 9) != 0, $urandom_range(0, 7) != 0);
      end else if (pick < 85) begin
        // Truncated reply: the next request abandons it.
        send_reply($urandom_range(1, reply_len_now - 1), 1'b1, 1'b1);
      end else if (pick < 93) begin
        // Clean reply followed by stray bytes that nobody waits for.
        send_reply(reply_len_now, 1'b1, 1'b1);
        repeat ($urandom_range(1, 3)) rx(8'($urandom));
      end
      // Otherwise leave the request unanswered.
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset slave id.
    rx(8'hFF);                                          // nothing pending: dropped
    request(CMD_ACTION, 8'hFF, 8'h00, 8'h00, 8'h00);
    request(CMD_POSITION, 8'h00, 8'h00, 8'h00, 8'h00);  // abandons the action reply
    request(CMD_POSITION, 8'h00, 8'hFF, 8'hFF, 8'hFF);  // abandons again
    request(CMD_STATUS, 8'h00, 8'h00, 8'h00, 8'h00);
    send_reply(READ_REPLY_LEN, 1'b1, 1'b1);             // clean status reply
    rx(8'h00);                                          // after the verdict: dropped
    request(CMD_ACTION, 8'h00, 8'h00, 8'h00, 8'h00);
    send_reply(WRITE_REPLY_LEN, 1'b0, 1'b0);            // wrong id and broken frame

    // Random part over three idle profiles and three slave ids, extremes among them.
    run_phase(8'd0, 21, 86, 140);
    run_phase(8'd247, 86, 21, 250);
    run_phase(8'(($urandom_range(0, 14) << 4) | 8), 0, 0, 355);

    settle();
    if (mismatches == 0) begin
      $display("modbus_rtu_gripper_framer_top_tb: clean");
    end else begin
      $display("modbus_rtu_gripper_framer_top_tb: errors");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #5_000_000;
    $display("modbus_rtu_gripper_framer_top_tb: errors");
    $finish;
  end

endmodule
